// ===== design/biquad_iir_df2_top_assert.svh =====
// Assertion macros used by the filter control module.
// Each macro expects signals named clk and rst in the enclosing module.
`ifndef BIQUAD_IIR_DF2_TOP_ASSERT_SVH
`define BIQUAD_IIR_DF2_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define BQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define BQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/bqdf2_pkg.sv =====
`timescale 1ns / 1ps

package bqdf2_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int COEF_BITS   = 32;
  localparam int COEF_FRAC   = COEF_BITS - 3;
  localparam int NUM_REGS    = 7;
  localparam int REG_IDX_W   = 3;
  localparam int DELAY_BITS  = 32;
  localparam int PROD_BITS   = 2 * COEF_BITS;
  localparam int ACC_BITS    = 38;
  localparam int GAIN_SHIFT  = COEF_FRAC - 16;
  localparam int OUT_SHIFT   = COEF_FRAC + 16;
  localparam int Y_BITS      = PROD_BITS - OUT_SHIFT;

  localparam logic signed [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(64'sd1 <<< COEF_FRAC);

  // Register indexes.
  localparam logic [REG_IDX_W-1:0] REG_B0  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_B1  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_B2  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_A1  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_A2  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_GIN = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_GOUT = 3'd6;

  // Multiplier operand pairs.
  localparam logic [2:0] MUL_G0X   = 3'd0;
  localparam logic [2:0] MUL_A1D1  = 3'd1;
  localparam logic [2:0] MUL_A2D2  = 3'd2;
  localparam logic [2:0] MUL_B1D1  = 3'd3;
  localparam logic [2:0] MUL_B2D2  = 3'd4;
  localparam logic [2:0] MUL_B0W   = 3'd5;
  localparam logic [2:0] MUL_G1ACC = 3'd6;

  // Accumulator operations on the registered product.
  localparam logic [2:0] ACC_HOLD    = 3'd0;
  localparam logic [2:0] ACC_LOAD_IN = 3'd1;
  localparam logic [2:0] ACC_LOAD    = 3'd2;
  localparam logic [2:0] ACC_ADD     = 3'd3;
  localparam logic [2:0] ACC_SUB     = 3'd4;
  localparam logic [2:0] ACC_SAT     = 3'd5;

  typedef struct packed {
    logic       load_x;
    logic       mul_en;
    logic [2:0] mul_sel;
    logic [2:0] acc_op;
    logic       w_latch;
    logic       out_load;
  } bqdf2_cmd_t;

endpackage

// ===== design/biquad_iir_df2_top.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake               Payload
// config    in         cfg_write               cfg_index, cfg_data
// input     in         in_valid / in_stall     sample_in
// output    out        out_valid / out_stall   sample_out, clipped
//
// Each input beat is first taken as a sample and then runs ten steps through the single
// shared 32x32 multiplier, which forms all seven products in turn.
// A new input beat is taken while the previous result still waits in the output register;
// only the last step waits for that register to be free.
// Reset sets the coefficients to pass-through and clears the delay line.
// Any write to a valid register index clears the delay line.

module biquad_iir_df2_top
  import bqdf2_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [REG_IDX_W-1:0]          cfg_index,
  input  logic [COEF_BITS-1:0]          cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] sample_out,
  output logic                          clipped
);

  bqdf2_cmd_t cmd;

  bqdf2_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  bqdf2_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .sample_in  (sample_in),
    .cmd        (cmd),
    .sample_out (sample_out),
    .clipped    (clipped)
  );

endmodule

// ===== design/bqdf2_dp.sv =====
`timescale 1ns / 1ps

module bqdf2_dp
  import bqdf2_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [REG_IDX_W-1:0]          cfg_index,
  input  logic [COEF_BITS-1:0]          cfg_data,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  input  bqdf2_cmd_t                    cmd,
  output logic signed [SAMPLE_BITS-1:0] sample_out,
  output logic                          clipped
);

  logic signed [COEF_BITS-1:0]   coef [NUM_REGS];
  logic signed [DELAY_BITS-1:0]  delay_one;
  logic signed [DELAY_BITS-1:0]  delay_two;
  logic signed [DELAY_BITS-1:0]  w;
  logic signed [SAMPLE_BITS-1:0] x;
  logic signed [PROD_BITS-1:0]   prod;
  logic signed [ACC_BITS-1:0]    acc;
  logic                          clip;

  logic                          cfg_ok;
  logic signed [COEF_BITS-1:0]   op_a;
  logic signed [COEF_BITS-1:0]   op_b;
  logic signed [ACC_BITS-1:0]    term_in;
  logic signed [ACC_BITS-1:0]    term_coef;
  logic signed [Y_BITS-1:0]      y_raw;
  logic                          y_ovf;
  logic signed [SAMPLE_BITS-1:0] y_sat;

  function automatic logic acc_ovf(input logic signed [ACC_BITS-1:0] v);
    logic [ACC_BITS-DELAY_BITS:0] top;
    top = v[ACC_BITS-1:DELAY_BITS-1];
    return !((&top) || (~|top));
  endfunction

  function automatic logic signed [DELAY_BITS-1:0] acc_clamp(
    input logic signed [ACC_BITS-1:0] v
  );
    logic signed [DELAY_BITS-1:0] r;
    if (!acc_ovf(v)) begin
      r = v[DELAY_BITS-1:0];
    end else if (v[ACC_BITS-1]) begin
      r = {1'b1, {(DELAY_BITS-1){1'b0}}};
    end else begin
      r = {1'b0, {(DELAY_BITS-1){1'b1}}};
    end
    return r;
  endfunction

  assign cfg_ok = cfg_write && (cfg_index < REG_IDX_W'(NUM_REGS));

  always_ff @(posedge clk) begin
    if (rst) begin
      coef[REG_B0]   <= COEF_ONE;
      coef[REG_B1]   <= '0;
      coef[REG_B2]   <= '0;
      coef[REG_A1]   <= '0;
      coef[REG_A2]   <= '0;
      coef[REG_GIN]  <= COEF_ONE;
      coef[REG_GOUT] <= COEF_ONE;
    end else if (cfg_ok) begin
      coef[cfg_index] <= cfg_data;
    end
  end

  always_comb begin
    case (cmd.mul_sel)
      MUL_G0X: begin
        op_a = coef[REG_GIN];
        op_b = COEF_BITS'(x);
      end
      MUL_A1D1: begin
        op_a = coef[REG_A1];
        op_b = delay_one;
      end
      MUL_A2D2: begin
        op_a = coef[REG_A2];
        op_b = delay_two;
      end
      MUL_B1D1: begin
        op_a = coef[REG_B1];
        op_b = delay_one;
      end
      MUL_B2D2: begin
        op_a = coef[REG_B2];
        op_b = delay_two;
      end
      MUL_B0W: begin
        op_a = coef[REG_B0];
        op_b = w;
      end
      MUL_G1ACC: begin
        op_a = coef[REG_GOUT];
        op_b = acc[DELAY_BITS-1:0];
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign term_in   = ACC_BITS'(prod >>> GAIN_SHIFT);
  assign term_coef = ACC_BITS'(prod >>> COEF_FRAC);

  assign y_raw = Y_BITS'(prod >>> OUT_SHIFT);
  assign y_ovf = !((&y_raw[Y_BITS-1:SAMPLE_BITS-1]) || (~|y_raw[Y_BITS-1:SAMPLE_BITS-1]));

  always_comb begin
    if (!y_ovf) begin
      y_sat = y_raw[SAMPLE_BITS-1:0];
    end else if (y_raw[Y_BITS-1]) begin
      y_sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      y_sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_x) begin
      x <= sample_in;
    end
    if (cmd.mul_en) begin
      prod <= op_a * op_b;
    end
    case (cmd.acc_op)
      ACC_HOLD:    acc <= acc;
      ACC_LOAD_IN: acc <= term_in;
      ACC_LOAD:    acc <= term_coef;
      ACC_ADD:     acc <= acc + term_coef;
      ACC_SUB:     acc <= acc - term_coef;
      ACC_SAT:     acc <= ACC_BITS'(acc_clamp(acc));
      default:     acc <= acc;
    endcase
    if (cmd.w_latch) begin
      w <= acc_clamp(acc);
    end
    if (cmd.load_x) begin
      clip <= 1'b0;
    end else if ((cmd.w_latch || (cmd.acc_op == ACC_SAT)) && acc_ovf(acc)) begin
      clip <= 1'b1;
    end
    if (cmd.out_load) begin
      sample_out <= y_sat;
      clipped    <= clip || y_ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_ok) begin
      delay_one <= '0;
      delay_two <= '0;
    end else if (cmd.out_load) begin
      delay_one <= w;
      delay_two <= delay_one;
    end
  end

endmodule

// ===== design/bqdf2_ctrl.sv =====
`timescale 1ns / 1ps
`include "biquad_iir_df2_top_assert.svh"

module bqdf2_ctrl
  import bqdf2_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  output bqdf2_cmd_t cmd
);

  localparam logic [0:0] ST_IDLE = 1'b0;
  localparam logic [0:0] ST_RUN  = 1'b1;
  localparam logic [3:0] STEP_LAST = 4'd9;

  logic [0:0] state;
  logic [0:0] state_next;
  logic [3:0] step;
  logic [3:0] step_next;
  logic       out_valid_next;
  logic       accept;
  logic       out_free;
  logic       finish;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && (state == ST_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign finish   = (state == ST_RUN) && (step == STEP_LAST) && out_free;

  always_comb begin
    cmd          = '0;
    cmd.mul_sel  = MUL_G0X;
    cmd.acc_op   = ACC_HOLD;
    cmd.load_x   = accept;
    if (state == ST_RUN) begin
      case (step)
        4'd0: begin
          cmd.mul_en  = 1'b1;
          cmd.mul_sel = MUL_G0X;
        end
        4'd1: begin
          cmd.mul_en  = 1'b1;
          cmd.mul_sel = MUL_A1D1;
          cmd.acc_op  = ACC_LOAD_IN;
        end
        4'd2: begin
          cmd.mul_en  = 1'b1;
          cmd.mul_sel = MUL_A2D2;
          cmd.acc_op  = ACC_SUB;
        end
        4'd3: begin
          cmd.mul_en  = 1'b1;
          cmd.mul_sel = MUL_B1D1;
          cmd.acc_op  = ACC_SUB;
        end
        4'd4: begin
          cmd.mul_en  = 1'b1;
          cmd.mul_sel = MUL_B2D2;
          cmd.acc_op  = ACC_LOAD;
          cmd.w_latch = 1'b1;
        end
        4'd5: begin
          cmd.mul_en  = 1'b1;
          cmd.mul_sel = MUL_B0W;
          cmd.acc_op  = ACC_ADD;
        end
        4'd6: begin
          cmd.acc_op  = ACC_ADD;
        end
        4'd7: begin
          cmd.acc_op  = ACC_SAT;
        end
        4'd8: begin
          cmd.mul_en  = 1'b1;
          cmd.mul_sel = MUL_G1ACC;
        end
        4'd9: begin
          cmd.out_load = out_free;
        end
        default: begin
          cmd.acc_op  = ACC_HOLD;
        end
      endcase
    end
  end

  always_comb begin
    state_next     = state;
    step_next      = step;
    out_valid_next = out_valid && out_stall;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_RUN;
          step_next  = '0;
        end
      end
      ST_RUN: begin
        if (step != STEP_LAST) begin
          step_next = step + 4'd1;
        end else if (finish) begin
          state_next     = ST_IDLE;
          step_next      = '0;
          out_valid_next = 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
        step_next  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

  `BQ_ASSERT_NXT(a_finish_shows_result, finish, out_valid, "Result not shown after last step.")
  `BQ_ASSERT_NXT(a_accept_starts_run, accept, (state == ST_RUN) && (step == 4'd0), "Run did not start.")
  `BQ_ASSERT_IMP(a_idle_step_zero, state == ST_IDLE, step == 4'd0, "Step counter busy while idle.")
  `BQ_ASSERT_IMP(a_step_bound, state == ST_RUN, step <= STEP_LAST, "Step counter out of range.")
  `BQ_ASSERT_IMP(a_load_only_free, cmd.out_load, out_free && (step == STEP_LAST), "Output loaded while held.")

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import bqdf2_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam logic [REG_IDX_W-1:0] REG_NONE = 3'd7;
  localparam logic signed [COEF_BITS-1:0] COEF_MAX = {1'b0, {(COEF_BITS-1){1'b1}}};
  localparam logic signed [COEF_BITS-1:0] COEF_MIN = {1'b1, {(COEF_BITS-1){1'b0}}};

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          clip;
  } filter_out_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_write = 1'b0;
  logic [REG_IDX_W-1:0]          cfg_index = '0;
  logic [COEF_BITS-1:0]          cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic signed [SAMPLE_BITS-1:0] sample_in = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          clipped;

  logic signed [COEF_BITS-1:0] coefs [NUM_REGS];
  longint                      delay_one;
  longint                      delay_two;
  filter_out_t                 expected_outputs [$];
  int                          mismatches = 0;
  int                          cycle_count = 0;
  int                          send_idle_pct = 0;
  int                          stall_pct = 0;

  biquad_iir_df2_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .sample_in (sample_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sample_out(sample_out),
    .clipped   (clipped)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic longint clamp(input longint v, input int bits, inout logic hit);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      hit = 1'b1;
      return hi;
    end
    if (v < lo) begin
      hit = 1'b1;
      return lo;
    end
    return v;
  endfunction

  // Works out the output of one sample and advances the delay line.
  function automatic filter_out_t filter_step(input logic signed [SAMPLE_BITS-1:0] x);
    longint      w;
    longint      acc;
    longint      y;
    logic        hit;
    filter_out_t r;
    hit = 1'b0;
    w = ((longint'(coefs[REG_GIN]) * longint'(x)) >>> GAIN_SHIFT)
      - ((longint'(coefs[REG_A1]) * delay_one) >>> COEF_FRAC)
      - ((longint'(coefs[REG_A2]) * delay_two) >>> COEF_FRAC);
    w = clamp(w, DELAY_BITS, hit);
    acc = ((longint'(coefs[REG_B0]) * w) >>> COEF_FRAC)
        + ((longint'(coefs[REG_B1]) * delay_one) >>> COEF_FRAC)
        + ((longint'(coefs[REG_B2]) * delay_two) >>> COEF_FRAC);
    acc = clamp(acc, DELAY_BITS, hit);
    y = (longint'(coefs[REG_GOUT]) * acc) >>> OUT_SHIFT;
    y = clamp(y, SAMPLE_BITS, hit);
    delay_two = delay_one;
    delay_one = w;
    r.sample = y[SAMPLE_BITS-1:0];
    r.clip = hit;
    return r;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
    case ($urandom_range(9))
      0: return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      1: return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      2, 3, 4: return SAMPLE_BITS'(int'($urandom_range(511)) - 256);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  function automatic logic signed [COEF_BITS-1:0] mild_coef(input int unsigned lim);
    return COEF_BITS'(int'($urandom_range(2 * lim)) - int'(lim));
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    mismatches++;
  endtask

  // Receiver: random back-pressure and the check of every accepted result beat.
  always @(posedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    if (!rst && out_valid === 1'b1 && !out_stall) begin
      if (expected_outputs.size() == 0) begin
        report_mismatch("unexpected result beat, sample_out", sample_out, 0);
      end else begin
        if (sample_out !== expected_outputs[0].sample)
          report_mismatch("sample_out", sample_out, expected_outputs[0].sample);
        if (clipped !== expected_outputs[0].clip)
          report_mismatch("clipped", clipped, expected_outputs[0].clip);
        void'(expected_outputs.pop_front());
      end
    end
  end

  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] x);
    int gap;
    gap = 0;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample_in <= x;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_outputs.push_back(filter_step(x));
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (expected_outputs.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [COEF_BITS-1:0] data,
                           input bit last);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    if (idx < NUM_REGS) begin
      coefs[idx] = data;
      delay_one = 0;
      delay_two = 0;
    end
    if (last) cfg_write <= 1'b0;
  endtask

  task automatic set_coefs(input logic [COEF_BITS-1:0] b0, input logic [COEF_BITS-1:0] b1,
                           input logic [COEF_BITS-1:0] b2, input logic [COEF_BITS-1:0] a1,
                           input logic [COEF_BITS-1:0] a2, input logic [COEF_BITS-1:0] gin,
                           input logic [COEF_BITS-1:0] gout);
    wait_for_results();
    write_reg(REG_B0, b0, 1'b0);
    write_reg(REG_B1, b1, 1'b0);
    write_reg(REG_B2, b2, 1'b0);
    write_reg(REG_A1, a1, 1'b0);
    write_reg(REG_A2, a2, 1'b0);
    write_reg(REG_GIN, gin, 1'b0);
    write_reg(REG_GOUT, gout, 1'b1);
  endtask

  task automatic test_passthrough();
    send_sample(16'sd0);
    send_sample(16'sd1);
    send_sample(-16'sd1);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sh5555);
    send_sample(16'shAAAA);
  endtask

  task automatic test_saturation();
    set_coefs(COEF_ONE, '0, '0, '0, '0, COEF_MAX, COEF_ONE);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    set_coefs(COEF_MAX, '0, '0, '0, '0, COEF_ONE, COEF_ONE);
    send_sample(16'sh7FFF);
    set_coefs(COEF_ONE, '0, '0, '0, '0, COEF_ONE, COEF_MAX);
    send_sample(16'sd20000);
    send_sample(-16'sd20000);
  endtask

  // A write to an unused index must keep the delay line; a real write clears it.
  task automatic test_delay_line_writes();
    set_coefs(COEF_ONE, COEF_ONE >>> 1, COEF_ONE >>> 2, -(COEF_ONE >>> 1), COEF_ONE >>> 2,
              COEF_ONE, COEF_ONE);
    send_sample(16'sd10000);
    send_sample(16'sd0);
    send_sample(-16'sd7000);
    wait_for_results();
    write_reg(REG_NONE, $urandom, 1'b1);
    send_sample(16'sd0);
    send_sample(16'sd0);
    wait_for_results();
    write_reg(REG_B1, COEF_ONE >>> 1, 1'b1);
    send_sample(16'sd0);
    send_sample(16'sd1234);
  endtask

  task automatic test_extreme_negative_coefs();
    set_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
    send_sample(16'sd1);
    send_sample(-16'sd1);
    send_sample(16'sd0);
  endtask

  task automatic test_random_filters();
    int count;
    for (int phase = 0; phase < 4; phase++) begin
      for (int s = 0; s < 6; s++) begin
        wait_for_results();
        case (phase)
          0: begin send_idle_pct = 0;  stall_pct = 0;  end
          1: begin send_idle_pct = 60; stall_pct = 0;  end
          2: begin send_idle_pct = 0;  stall_pct = 60; end
          default: begin send_idle_pct = 37; stall_pct = 37; end
        endcase
        count = 62;
        if (s == 0) begin
          set_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
          count = 16;
        end else if (s == 1) begin
          set_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
          count = 16;
        end else if (s == 5) begin
          set_coefs($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        end else begin
          set_coefs(mild_coef(1 << 29), mild_coef(1 << 29), mild_coef(1 << 29),
                    mild_coef(3 << 28), mild_coef(3 << 27), mild_coef(3 << 28),
                    mild_coef(3 << 28));
        end
        if ($urandom_range(1) == 1) write_reg(REG_NONE, $urandom, 1'b1);
        repeat (count) send_sample(random_sample());
      end
    end
  endtask

  initial begin
    coefs[REG_B0] = COEF_ONE;
    coefs[REG_B1] = '0;
    coefs[REG_B2] = '0;
    coefs[REG_A1] = '0;
    coefs[REG_A2] = '0;
    coefs[REG_GIN] = COEF_ONE;
    coefs[REG_GOUT] = COEF_ONE;
    delay_one = 0;
    delay_two = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_passthrough();
    test_saturation();
    test_delay_line_writes();
    test_extreme_negative_coefs();
    test_random_filters();
    wait_for_results();
    repeat (30) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== biquad_iir_df2_top.f =====
+incdir+design
design/bqdf2_pkg.sv
design/bqdf2_dp.sv
design/bqdf2_ctrl.sv
design/biquad_iir_df2_top.sv
tb/testbench.sv
